[rtl/sha1sh_pkg.sv]
// Package of the SHA-1 stream hasher: controller states, the command and
// status structs between controller and datapath, and the SHA-1 constants.
// No dependencies.
package sha1sh_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } state_e;

  // Source of the byte shifted into the block buffer.
  typedef enum logic [1:0] {
    BSEL_INPUT,
    BSEL_MARK,
    BSEL_ZERO,
    BSEL_LEN
  } byte_sel_e;

  typedef struct packed {
    logic      shift_byte;
    byte_sel_e byte_sel;
    logic      count_len;
    logic      load_work;
    logic      round_step;
    logic      fold;
    logic      emit_step;
    logic      reload;
  } dp_cmd_t;

  typedef struct packed {
    logic [5:0] byte_cnt;
    logic       round_last;
    logic       emit_last;
  } dp_stat_t;

  localparam logic [5:0] LAST_BYTE_POS = 6'd63;
  localparam logic [5:0] LEN_BYTE_POS  = 6'd56;
  localparam logic [6:0] LAST_ROUND    = 7'd79;
  localparam logic [2:0] LAST_WORD_IDX = 3'd4;
  localparam logic [7:0] PAD_MARK      = 8'h80;

  localparam logic [31:0] K_00_19 = 32'h5a827999;
  localparam logic [31:0] K_20_39 = 32'h6ed9eba1;
  localparam logic [31:0] K_40_59 = 32'h8f1bbcdc;
  localparam logic [31:0] K_60_79 = 32'hca62c1d6;

  // Initial hash value, word 0 in the lowest slice.
  localparam logic [4:0][31:0] H_INIT = {
    32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
  };

endpackage

[rtl/sha1sh_ctrl.sv]
// Controller of the SHA-1 stream hasher: sequences byte intake, padding,
// length insertion, the compression rounds and the digest output.
// Depends on sha1sh_pkg.
module sha1sh_ctrl
  import sha1sh_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_has_byte_i,
  input  logic     in_eom_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic   eom_q, eom_d;    // message end is pending
  logic   mark_q, mark_d;  // the 0x80 marker has been placed
  logic   fin_q, fin_d;    // the block under compression is the final one

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      eom_q   <= 1'b0;
      mark_q  <= 1'b0;
      fin_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      eom_q   <= eom_d;
      mark_q  <= mark_d;
      fin_q   <= fin_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    eom_d       = eom_q;
    mark_d      = mark_q;
    fin_d       = fin_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    cmd_o.byte_sel = BSEL_INPUT;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_eom_i) begin
            eom_d = 1'b1;
          end
          if (in_has_byte_i) begin
            cmd_o.shift_byte = 1'b1;
            cmd_o.count_len  = 1'b1;
            if (stat_i.byte_cnt == LAST_BYTE_POS) begin
              cmd_o.load_work = 1'b1;
              state_d         = ST_ROUND;
            end else if (in_eom_i) begin
              state_d = ST_PAD;
            end
          end else if (in_eom_i) begin
            state_d = ST_PAD;
          end
        end
      end

      ST_PAD: begin
        if (mark_q && stat_i.byte_cnt == LEN_BYTE_POS) begin
          state_d = ST_LEN;
        end else begin
          cmd_o.shift_byte = 1'b1;
          cmd_o.byte_sel   = mark_q ? BSEL_ZERO : BSEL_MARK;
          mark_d           = 1'b1;
          if (stat_i.byte_cnt == LAST_BYTE_POS) begin
            cmd_o.load_work = 1'b1;
            state_d         = ST_ROUND;
          end
        end
      end

      ST_LEN: begin
        cmd_o.shift_byte = 1'b1;
        cmd_o.byte_sel   = BSEL_LEN;
        if (stat_i.byte_cnt == LAST_BYTE_POS) begin
          cmd_o.load_work = 1'b1;
          fin_d           = 1'b1;
          state_d         = ST_ROUND;
        end
      end

      ST_ROUND: begin
        cmd_o.round_step = 1'b1;
        if (stat_i.round_last) begin
          state_d = ST_FOLD;
        end
      end

      ST_FOLD: begin
        cmd_o.fold = 1'b1;
        if (fin_q) begin
          state_d = ST_EMIT;
        end else if (eom_q) begin
          state_d = ST_PAD;
        end else begin
          state_d = ST_IDLE;
        end
      end

      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.emit_step = 1'b1;
          if (stat_i.emit_last) begin
            cmd_o.reload = 1'b1;
            eom_d        = 1'b0;
            mark_d       = 1'b0;
            fin_d        = 1'b0;
            state_d      = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/sha1sh_dp.sv]
// Datapath of the SHA-1 stream hasher: block buffer and rolling message
// schedule, round registers, hash state, byte, length, round and word counters.
// Depends on sha1sh_pkg.
module sha1sh_dp
  import sha1sh_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_cmd_t     cmd_i,
  input  logic [7:0]  data_byte_i,
  output dp_stat_t    stat_o,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o
);

  logic [31:0] sched_q [16];
  logic [31:0] sched_d [16];
  logic [31:0] work_q [5];
  logic [31:0] work_d [5];
  logic [31:0] hash_q [5];
  logic [31:0] hash_d [5];
  logic [5:0]  cnt_q, cnt_d;
  logic [63:0] len_q, len_d;
  logic [6:0]  rnd_q, rnd_d;
  logic [2:0]  emit_q, emit_d;

  logic [7:0]  byte_in;
  logic [63:0] len_shift;
  logic [31:0] w_next;
  logic [31:0] f_val;
  logic [31:0] k_val;
  logic [31:0] t_val;

  // Length bytes go out most significant first at positions 56 to 63.
  assign len_shift = len_q >> {~cnt_q[2:0], 3'b000};

  always_comb begin
    case (cmd_i.byte_sel)
      BSEL_INPUT: byte_in = data_byte_i;
      BSEL_MARK:  byte_in = PAD_MARK;
      BSEL_ZERO:  byte_in = 8'h00;
      BSEL_LEN:   byte_in = len_shift[7:0];
      default:    byte_in = 8'h00;
    endcase
  end

  assign w_next = {sched_q[13] ^ sched_q[8] ^ sched_q[2] ^ sched_q[0]} << 1 |
                  {31'd0, sched_q[13][31] ^ sched_q[8][31] ^ sched_q[2][31] ^ sched_q[0][31]};

  always_comb begin
    if (rnd_q < 7'd20) begin
      f_val = (work_q[1] & work_q[2]) | (~work_q[1] & work_q[3]);
      k_val = K_00_19;
    end else if (rnd_q < 7'd40) begin
      f_val = work_q[1] ^ work_q[2] ^ work_q[3];
      k_val = K_20_39;
    end else if (rnd_q < 7'd60) begin
      f_val = (work_q[1] & work_q[2]) | (work_q[1] & work_q[3]) |
              (work_q[2] & work_q[3]);
      k_val = K_40_59;
    end else begin
      f_val = work_q[1] ^ work_q[2] ^ work_q[3];
      k_val = K_60_79;
    end
  end

  assign t_val = {work_q[0][26:0], work_q[0][31:27]} + f_val + work_q[4] + k_val +
                 sched_q[0];

  always_comb begin
    sched_d = sched_q;
    work_d  = work_q;
    hash_d  = hash_q;
    cnt_d   = cnt_q;
    len_d   = len_q;
    rnd_d   = rnd_q;
    emit_d  = emit_q;

    // Bytes enter at the bottom so that the first byte ends up in the top
    // byte of word 0 once the block is full.
    if (cmd_i.shift_byte) begin
      for (int i = 0; i < 15; i++) begin
        sched_d[i] = {sched_q[i][23:0], sched_q[i+1][31:24]};
      end
      sched_d[15] = {sched_q[15][23:0], byte_in};
      cnt_d       = cnt_q + 6'd1;
    end
    if (cmd_i.count_len) begin
      len_d = len_q + 64'd8;
    end
    if (cmd_i.load_work) begin
      work_d = hash_q;
      rnd_d  = 7'd0;
    end

    // Word 0 always holds the schedule word of the current round.
    if (cmd_i.round_step) begin
      for (int i = 0; i < 15; i++) begin
        sched_d[i] = sched_q[i+1];
      end
      sched_d[15] = w_next;
      work_d[0]   = t_val;
      work_d[1]   = work_q[0];
      work_d[2]   = {work_q[1][1:0], work_q[1][31:2]};
      work_d[3]   = work_q[2];
      work_d[4]   = work_q[3];
      rnd_d       = (rnd_q == LAST_ROUND) ? 7'd0 : rnd_q + 7'd1;
    end
    if (cmd_i.fold) begin
      for (int i = 0; i < 5; i++) begin
        hash_d[i] = hash_q[i] + work_q[i];
      end
    end
    if (cmd_i.emit_step) begin
      emit_d = emit_q + 3'd1;
    end
    if (cmd_i.reload) begin
      for (int i = 0; i < 5; i++) begin
        hash_d[i] = H_INIT[i];
      end
      cnt_d  = 6'd0;
      len_d  = 64'd0;
      emit_d = 3'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 5; i++) begin
        hash_q[i] <= H_INIT[i];
      end
      cnt_q  <= 6'd0;
      len_q  <= 64'd0;
      rnd_q  <= 7'd0;
      emit_q <= 3'd0;
    end else begin
      hash_q <= hash_d;
      cnt_q  <= cnt_d;
      len_q  <= len_d;
      rnd_q  <= rnd_d;
      emit_q <= emit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sched_q <= sched_d;
    work_q  <= work_d;
  end

  always_comb begin
    case (emit_q)
      3'd0:    digest_word_o = hash_q[0];
      3'd1:    digest_word_o = hash_q[1];
      3'd2:    digest_word_o = hash_q[2];
      3'd3:    digest_word_o = hash_q[3];
      3'd4:    digest_word_o = hash_q[4];
      default: digest_word_o = 32'd0;
    endcase
  end

  assign word_index_o      = emit_q;
  assign stat_o.byte_cnt   = cnt_q;
  assign stat_o.round_last = (rnd_q == LAST_ROUND);
  assign stat_o.emit_last  = (emit_q == LAST_WORD_IDX);

endmodule

[rtl/sha1_stream_hasher_unit.sv]
// Top level of the SHA-1 stream hasher: joins the controller and the datapath
// to the input and output streams.
// Depends on sha1sh_pkg, sha1sh_ctrl and sha1sh_dp.
//
//   Channel  Direction  Payload
//   s_axis   in         tdata = data_byte, tuser = has_byte, tlast = end_of_message
//   m_axis   out        tdata = digest_word, tuser = word_index, tlast = last_word
//
// A message byte is shifted straight into the block; a full 64-byte block then runs the
// 80 rounds and a fold step that adds the round registers into the hash state.
// At message end the marker and zero bytes enter one per cycle up to byte 56, a
// step without a byte switches to the length, whose eight bytes follow, and each
// padded block runs the rounds and the fold (two blocks when at most eight bytes were left).
// Reset loads the initial hash value and clears the counters; the input is ready
// only when idle, and each of the five digest words holds until its transfer.
module sha1_stream_hasher_unit
  import sha1sh_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tuser_i,   // [0] has_byte
  input  logic        s_axis_tlast_i,   // end_of_message
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] digest_word
  output logic [2:0]  m_axis_tuser_o,   // [2:0] word_index
  output logic        m_axis_tlast_o    // last_word
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sha1sh_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid_i),
    .in_has_byte_i (s_axis_tuser_i),
    .in_eom_i      (s_axis_tlast_i),
    .in_ready_o    (s_axis_tready_o),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .stat_i        (stat),
    .cmd_o         (cmd)
  );

  sha1sh_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .data_byte_i   (s_axis_tdata_i),
    .stat_o        (stat),
    .digest_word_o (m_axis_tdata_o),
    .word_index_o  (m_axis_tuser_o)
  );

  // The final word is the one with index four.
  assign m_axis_tlast_o = (m_axis_tuser_o == LAST_WORD_IDX);

  // No input transfer is taken while a digest is being delivered.
  a_no_intake_during_output : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !s_axis_tready_o
  ) else $error("input ready while a digest word is pending");

  // A digest always starts with word zero.
  a_first_word_zero : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> (m_axis_tuser_o == 3'd0)
  ) else $error("digest does not start with word zero");

  // Words follow one another in order.
  a_word_order : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o) |=>
      (m_axis_tvalid_o && m_axis_tuser_o == $past(m_axis_tuser_o) + 3'd1)
  ) else $error("digest words out of order");

  // After the last word the output goes quiet.
  a_stop_after_last : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o) |=> !m_axis_tvalid_o
  ) else $error("output still valid after the last digest word");

endmodule

[tb/sha1_digest_sb.sv]
// Scoreboard package for the SHA-1 stream hasher testbench: a bit-exact
// SHA-1 digest predictor and the queue of digest words still awaited.
// No dependencies.
package sha1_digest_sb_pkg;

  typedef struct {
    bit [31:0] word;
    bit [2:0]  pos_idx;
    bit        is_last;
  } digest_beat_t;

  class digest_scoreboard;
    localparam bit [31:0] IV0 = 32'h67452301;
    localparam bit [31:0] IV1 = 32'hefcdab89;
    localparam bit [31:0] IV2 = 32'h98badcfe;
    localparam bit [31:0] IV3 = 32'h10325476;
    localparam bit [31:0] IV4 = 32'hc3d2e1f0;
    localparam bit [31:0] KR0 = 32'h5a827999;
    localparam bit [31:0] KR1 = 32'h6ed9eba1;
    localparam bit [31:0] KR2 = 32'h8f1bbcdc;
    localparam bit [31:0] KR3 = 32'hca62c1d6;
    localparam bit [7:0]  MARK_BYTE = 8'h80;

    bit [31:0]    hval[5];
    bit [31:0]    blk[16];
    bit [5:0]     fill;
    bit [63:0]    nbits;
    digest_beat_t awaited_q[$];
    int unsigned  errors;

    function new();
      errors = 0;
      restart();
      foreach (blk[i]) blk[i] = '0;
    endfunction

    // Back to the initial hash value with an empty block and zero length.
    function void restart();
      hval[0] = IV0;
      hval[1] = IV1;
      hval[2] = IV2;
      hval[3] = IV3;
      hval[4] = IV4;
      foreach (blk[i]) blk[i] = '0;
      fill  = '0;
      nbits = '0;
    endfunction

    function bit [31:0] rol(bit [31:0] v, int n);
      return (v << n) | (v >> (32 - n));
    endfunction

    // Bytes go in big-endian: position 0 is the top byte of word 0.
    function void place_byte(int pos, bit [7:0] v);
      blk[pos >> 2][31 - 8 * (pos & 3) -: 8] = v;
    endfunction

    // 80 rounds with the schedule rolling in place over the 16 block words.
    function void mix_block();
      bit [31:0] a, b, c, d, e, f, k, t;
      int s;
      a = hval[0];
      b = hval[1];
      c = hval[2];
      d = hval[3];
      e = hval[4];
      for (int r = 0; r < 80; r++) begin
        s = r & 15;
        if (r >= 16)
          blk[s] = rol(blk[(s + 13) & 15] ^ blk[(s + 8) & 15] ^
                       blk[(s + 2) & 15] ^ blk[s], 1);
        if (r < 20) begin
          f = (b & c) | (~b & d);
          k = KR0;
        end else if (r < 40) begin
          f = b ^ c ^ d;
          k = KR1;
        end else if (r < 60) begin
          f = (b & c) | (b & d) | (c & d);
          k = KR2;
        end else begin
          f = b ^ c ^ d;
          k = KR3;
        end
        t = rol(a, 5) + f + e + k + blk[s];
        e = d;
        d = c;
        c = rol(b, 30);
        b = a;
        a = t;
      end
      hval[0] += a;
      hval[1] += b;
      hval[2] += c;
      hval[3] += d;
      hval[4] += e;
    endfunction

    // An accepted input transfer: absorb the byte, and on end of message
    // pad, append the length, and queue the five digest words.
    function void note_input(bit [7:0] data, bit has_byte, bit eom);
      int c;
      digest_beat_t beat;
      if (has_byte) begin
        place_byte(int'(fill), data);
        nbits += 64'd8;
        fill  += 6'd1;
        if (fill == 6'd0) mix_block();
      end
      if (eom) begin
        c = int'(fill);
        place_byte(c, MARK_BYTE);
        for (int p = c + 1; p < 64; p++) place_byte(p, 8'h00);
        // No room for the length: it goes into an extra, otherwise empty block.
        if (c >= 56) begin
          mix_block();
          foreach (blk[i]) blk[i] = '0;
        end
        blk[14] = nbits[63:32];
        blk[15] = nbits[31:0];
        mix_block();
        for (int w = 0; w < 5; w++) begin
          beat.word    = hval[w];
          beat.pos_idx = w[2:0];
          beat.is_last = (w == 4);
          awaited_q.push_back(beat);
        end
        restart();
      end
    endfunction

    function void check_result(bit [31:0] word, bit [2:0] pos_idx, bit is_last);
      digest_beat_t exp_b;
      if (awaited_q.size() == 0) begin
        $display("%0t: digest word %h index %0d last %0d arrived with none awaited",
                 $time, word, pos_idx, is_last);
        errors++;
        return;
      end
      exp_b = awaited_q.pop_front();
      if (word !== exp_b.word) begin
        $display("%0t: digest word expected %h actual %h", $time, exp_b.word, word);
        errors++;
      end
      if (pos_idx !== exp_b.pos_idx) begin
        $display("%0t: word index expected %0d actual %0d", $time, exp_b.pos_idx, pos_idx);
        errors++;
      end
      if (is_last !== exp_b.is_last) begin
        $display("%0t: last word flag expected %0d actual %0d", $time, exp_b.is_last, is_last);
        errors++;
      end
    endfunction

    function int pending();
      return awaited_q.size();
    endfunction
  endclass

endpackage

[tb/tb_top.sv]
// Testbench top of the SHA-1 stream hasher: drives byte streams with random
// gaps and sink stalls and checks every digest word against a predictor.
// Depends on sha1_digest_sb_pkg and the sha1_stream_hasher_unit RTL.
module tb_top;
  import sha1_digest_sb_pkg::*;

  // A full random run stays well below this; anything beyond it is a hang.
  localparam int unsigned CYCLE_LIMIT = 300000;
  // Idle cycles after the last digest word, enough for two padded blocks.
  localparam int DRAIN_CYCLES = 250;
  localparam int unsigned ITEM_TARGET = 310;

  // Sink ready patterns.
  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_COIN,
    RX_SPARSE,
    RX_PERIODIC
  } rx_mode_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_valid = 1'b0;
  logic [7:0]  s_data = 8'h00;
  logic        s_user = 1'b0;
  logic        s_last = 1'b0;
  logic        s_ready;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [31:0] m_data;
  logic [2:0]  m_user;
  logic        m_last;

  digest_scoreboard sb;
  int unsigned cycle_cnt = 0;
  int unsigned fed_items = 0;
  int          burst_left = 0;
  rx_mode_e    rx_mode = RX_ALWAYS;
  int          rx_left = 0;
  int unsigned rx_tick = 0;

  sha1_stream_hasher_unit uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),   // [7:0] data_byte
    .s_axis_tuser_i  (s_user),   // [0] has_byte
    .s_axis_tlast_i  (s_last),   // end_of_message
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),   // [31:0] digest_word
    .m_axis_tuser_o  (m_user),   // [2:0] word_index
    .m_axis_tlast_o  (m_last)    // last_word
  );

  always #1 clk = ~clk;

  // The whole run is bounded so that a stuck handshake ends as a failure.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // The sink switches between ready patterns at random intervals, so
  // stalls land on every digest word position, with stall-free stretches too.
  always @(negedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rx_left == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 3));
      rx_left <= $urandom_range(20, 200);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_ALWAYS:   m_ready <= 1'b1;
      RX_COIN:     m_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE:   m_ready <= ($urandom_range(0, 5) == 0);
      default:     m_ready <= ((rx_tick % 7) < 3);
    endcase
  end

  // Outputs are sampled at the rising edge, before the design's flops move.
  always @(posedge clk) begin
    if (rst_n && m_valid && m_ready) sb.check_result(m_data, m_user, m_last);
  end

  // One input transfer. The task is entered and left at a falling edge and
  // never lowers valid when the next item follows without a gap, so valid
  // sees at most one assignment per time step.
  task automatic send_item(input logic [7:0] data, input logic has_byte, input logic eom);
    int gap;
    int pick;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      pick = $urandom_range(0, 9);
      if (pick < 5) gap = 0;
      else if (pick < 9) gap = $urandom_range(1, 4);
      else gap = $urandom_range(20, 90);
      if (gap > 0) begin
        s_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    s_valid <= 1'b1;
    s_data  <= data;
    s_user  <= has_byte;
    s_last  <= eom;
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    sb.note_input(data, has_byte, eom);
    if (has_byte || eom) fed_items++;
    @(negedge clk);
  endtask

  // Hold the sender off until every awaited digest word has been taken.
  // The wait always passes a falling edge, so valid never toggles within a step.
  task automatic hold_until_drained();
    s_valid <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  // A message of random bytes with the occasional empty transfer mixed in.
  // The end is either carried by the last byte or sent alone afterwards.
  task automatic send_message(input int len);
    bit end_alone;
    end_alone = (len == 0) || ($urandom_range(0, 1) == 1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_item(8'($urandom_range(0, 255)), 1'b1, (i == len - 1) && !end_alone);
    end
    if (end_alone) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  initial begin
    int len;
    int pick;
    int edge_lens[3];
    sb = new();
    edge_lens = '{55, 56, 64};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part: empty transfers with extreme data, the empty message,
    // "abc", one byte carrying the end, and an end sent after the last byte.
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    send_item(8'hff, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hff, 1'b0, 1'b1);
    hold_until_drained();

    // Lengths on the padding boundaries: the length just fits, needs an
    // extra block, and a full block with padding entirely in a second one.
    foreach (edge_lens[i]) send_message(edge_lens[i]);

    // Random messages, mostly short, some around one and two block sizes.
    while (fed_items < ITEM_TARGET) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) len = $urandom_range(0, 24);
      else if (pick == 6) len = $urandom_range(52, 66);
      else if (pick == 7) len = $urandom_range(118, 130);
      else if (pick == 8) len = 0;
      else len = $urandom_range(1, 8);
      send_message(len);
      if ($urandom_range(0, 7) == 0) hold_until_drained();
    end

    // Wait out the last digest, then some idle time for stray words.
    hold_until_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule
